// ===== design/q16alu_pkg.sv =====
// ----------------------------------------------------------------------------
// q16alu_pkg
// shared types and constants of the q16.16 saturating arithmetic unit
// ----------------------------------------------------------------------------
package q16alu_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumW     = DataW + FracBits;  // shifted dividend width
  localparam int unsigned NumCells = NumW;              // one quotient bit per cell

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // item as it walks along the divider cells
  typedef struct packed {
    logic                    valid;
    op_e                     op;
    logic signed [DataW-1:0] res;     // add, subtract or multiply result
    logic        [NumW-1:0]  numq;    // dividend bits out at the top, quotient in at the bottom
    logic        [DataW-1:0] rem;     // partial remainder
    logic        [DataW-1:0] dvsr;    // divisor magnitude
    logic                    neg;     // quotient sign
    logic                    dzero;   // zero divisor
  } cell_t;

  // item leaving the front end
  typedef struct packed {
    logic                      valid;
    op_e                       op;
    logic signed [DataW-1:0]   res;
    logic signed [2*DataW-1:0] prod;
    logic        [NumW-1:0]    num;
    logic        [DataW-1:0]   dvsr;
    logic                      neg;
    logic                      dzero;
  } front_t;

endpackage

// ===== design/q16alu_if.sv =====
// ----------------------------------------------------------------------------
// q16alu_in_if / q16alu_out_if
// valid/ready channels of the arithmetic unit
// ----------------------------------------------------------------------------
interface q16alu_in_if;
  import q16alu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [DataW-1:0] left_operand;
  logic signed [DataW-1:0] right_operand;
  modport source (output valid, opcode, left_operand, right_operand, input ready);
  modport sink   (input valid, opcode, left_operand, right_operand, output ready);
endinterface

interface q16alu_out_if;
  import q16alu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_value;
  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

// ===== design/q16_16_saturating_alu_top.sv =====
// ----------------------------------------------------------------------------
// q16_16_saturating_alu_top
// signed q16.16 add, subtract, multiply and divide with saturation
// ----------------------------------------------------------------------------
// pipeline: 51 register stages for every opcode alike
//   (input register, product register, 48 divider cells, result register)
// throughput: one item per cycle; the whole pipe stalls only while the
//   result register holds an item the sink has not taken
// reset: asynchronous, active low, clears every valid bit; no other state
module q16_16_saturating_alu_top
  import q16alu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  q16alu_in_if.sink    in_i,
  q16alu_out_if.source out_o
);

  // global advance: the pipe moves unless a result is waiting
  logic en;
  logic                    out_vld_q;
  logic signed [DataW-1:0] out_res_q, out_res_d;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  front_t front;

  q16alu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .opcode_i (in_i.opcode),
    .left_i   (in_i.left_operand),
    .right_i  (in_i.right_operand),
    .front_o  (front)
  );

  // multiply rounding: add half, shift right truncating toward zero, saturate
  logic signed [2*DataW-1:0] prod_rnd, prod_shr;
  logic signed [DataW-1:0]   mul_res;
  cell_t                     head;
  cell_t                     chain [NumCells+1];

  always_comb begin
    prod_rnd = front.prod + (2*DataW)'(64'd1 << (FracBits-1));
    prod_shr = prod_rnd >>> FracBits;
    // arithmetic shift floors; a negative value with dropped bits moves up one
    if (prod_rnd[2*DataW-1] && (prod_rnd[FracBits-1:0] != '0)) begin
      prod_shr = prod_shr + (2*DataW)'(1);
    end
    if (prod_shr > (2*DataW)'(SatMax)) begin
      mul_res = SatMax;
    end else if (prod_shr < (2*DataW)'(SatMin)) begin
      mul_res = SatMin;
    end else begin
      mul_res = prod_shr[DataW-1:0];
    end

    head.valid = front.valid;
    head.op    = front.op;
    head.res   = (front.op == OP_MUL) ? mul_res : front.res;
    head.numq  = front.num;
    head.rem   = '0;
    head.dvsr  = front.dvsr;
    head.neg   = front.neg;
    head.dzero = front.dzero;
  end

  assign chain[0] = head;

  // divider chain: each cell settles one quotient bit, msb first
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    q16alu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // quotient clamp to the positive limit, then sign
  cell_t           last;
  logic [NumW-1:0] quo;
  logic [DataW-1:0] qmag;

  always_comb begin
    last = chain[NumCells];
    quo  = last.numq;
    if ((quo[NumW-1:DataW-1] != '0) || (quo[DataW-2:0] == '1)) begin
      qmag = SatMax;
    end else begin
      qmag = quo[DataW-1:0];
    end
    case (last.op)
      OP_DIV: begin
        if (last.dzero) begin
          out_res_d = SatMax;
        end else if (last.neg) begin
          out_res_d = -$signed(qmag);
        end else begin
          out_res_d = $signed(qmag);
        end
      end
      default: out_res_d = last.res;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_value = out_res_q;

endmodule

// ===== design/q16alu_front.sv =====
// ----------------------------------------------------------------------------
// q16alu_front
// input register, add/subtract, product and divider set-up
// ----------------------------------------------------------------------------
module q16alu_front
  import q16alu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [1:0]              opcode_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  output front_t                  front_o
);

  logic                    vld_q;
  op_e                     op_q;
  logic signed [DataW-1:0] a_q, b_q;
  front_t                  front_q, front_d;

  logic signed [DataW:0]   sum;
  logic        [DataW-1:0] mag_a, mag_b;

  always_comb begin
    case (op_q)
      OP_SUB:  sum = {a_q[DataW-1], a_q} - {b_q[DataW-1], b_q};
      default: sum = {a_q[DataW-1], a_q} + {b_q[DataW-1], b_q};
    endcase
    mag_a = a_q[DataW-1] ? DataW'(-a_q) : DataW'(a_q);
    mag_b = b_q[DataW-1] ? DataW'(-b_q) : DataW'(b_q);

    front_d.valid = vld_q;
    front_d.op    = op_q;
    if (sum > $signed({SatMax[DataW-1], SatMax})) begin
      front_d.res = SatMax;
    end else if (sum < $signed({SatMin[DataW-1], SatMin})) begin
      front_d.res = SatMin;
    end else begin
      front_d.res = sum[DataW-1:0];
    end
    front_d.prod  = a_q * b_q;
    front_d.num   = {mag_a, {FracBits{1'b0}}};
    front_d.dvsr  = mag_b;
    front_d.neg   = a_q[DataW-1] ^ b_q[DataW-1];
    front_d.dzero = (b_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= 1'b0;
      front_q.valid <= 1'b0;
    end else if (en_i) begin
      vld_q   <= valid_i;
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_e'(opcode_i);
      a_q  <= left_i;
      b_q  <= right_i;
    end
  end

  assign front_o = front_q;

endmodule

// ===== design/q16alu_cell.sv =====
// ----------------------------------------------------------------------------
// q16alu_cell
// one restoring-division step: one quotient bit, registered
// ----------------------------------------------------------------------------
module q16alu_cell
  import q16alu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t         cell_q, cell_d;
  logic [DataW:0] trial, diff;

  always_comb begin
    trial  = {cell_i.rem, cell_i.numq[NumW-1]};
    diff   = trial - {1'b0, cell_i.dvsr};
    cell_d = cell_i;
    if (!diff[DataW]) begin
      cell_d.rem  = diff[DataW-1:0];
      cell_d.numq = {cell_i.numq[NumW-2:0], 1'b1};
    end else begin
      cell_d.rem  = trial[DataW-1:0];
      cell_d.numq = {cell_i.numq[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== tb/sv/q16_16_saturating_alu_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q16_16_saturating_alu_top_tb
// self-checking bench: directed corner items then random items through the
// valid/ready channels, each result compared against a local predictor
// ----------------------------------------------------------------------------
module q16_16_saturating_alu_top_tb;
  import q16alu_pkg::*;

  localparam int unsigned Latency   = 52;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldOff   = 300;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] lhs;
    logic signed [DataW-1:0] rhs;
  } alu_item_t;

  logic clk_i;
  logic rst_ni;

  q16alu_in_if  in_if ();
  q16alu_out_if out_if ();

  q16_16_saturating_alu_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  alu_item_t               pending_q[$];
  logic signed [DataW-1:0] expected_q[$];

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned idle_cnt;
  int unsigned op_seen[4];
  int unsigned send_gap_pct;  // chance in a hundred that the sender idles
  int unsigned recv_gap_pct;  // chance in a hundred that the receiver stalls
  int unsigned hold_cnt;      // cycles left in a long receiver hold-off
  bit          hold_req;
  bit          all_queued;

  // saturate a wide signed value to the int32 limits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SatMax;
    if (v < -66'sd2147483648) return SatMin;
    return v[DataW-1:0];
  endfunction

  // predicted result of one operation
  function automatic logic signed [DataW-1:0] alu_result(input alu_item_t it);
    logic signed [65:0] a, b, p;
    logic        [63:0] ma, mb, q;
    a = it.lhs;
    b = it.rhs;
    case (it.op)
      OP_ADD: return sat32(a + b);
      OP_SUB: return sat32(a - b);
      OP_MUL: begin
        p = a * b + 66'sd32768;
        // divide by 2^16 truncating toward zero
        p = p / 66'sd65536;
        return sat32(p);
      end
      default: begin
        if (b == 0) return SatMax;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        q  = (ma << FracBits) / mb;
        if (q >= 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return ((a < 0) != (b < 0)) ? -$signed(q[DataW-1:0]) : $signed(q[DataW-1:0]);
      end
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return SatMax;
      1: return SatMin;
      2: return 32'sd0;
      3: return $signed(32'($urandom_range(0, 3)) << FracBits) *
                (($urandom_range(0, 1) != 0) ? -1 : 1);
      4: return $signed($urandom_range(0, 2047)) - 1024;  // tiny values
      5: return $signed(32'($urandom) >> $urandom_range(0, 31));
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic add_item(input op_e op, input logic signed [DataW-1:0] lhs,
                          input logic signed [DataW-1:0] rhs);
    alu_item_t it;
    it.op  = op;
    it.lhs = lhs;
    it.rhs = rhs;
    pending_q.push_back(it);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // stimulus
  initial begin
    int unsigned k;
    rst_ni       = 1'b0;
    all_queued   = 1'b0;
    hold_req     = 1'b0;
    send_gap_pct = 18;
    recv_gap_pct = 88;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    add_item(OP_ADD, SatMax, 32'sd1);               // positive overflow
    add_item(OP_ADD, SatMin, -32'sd1);              // negative overflow
    add_item(OP_ADD, 32'sh0001_8000, 32'sh0002_4000);
    add_item(OP_SUB, SatMin, 32'sd1);
    add_item(OP_SUB, 32'sd0, SatMin);               // negating the minimum
    add_item(OP_SUB, SatMax, SatMax);
    add_item(OP_MUL, 32'sh0001_0000, 32'sh0001_0000);
    add_item(OP_MUL, 32'sd1, 32'sh0000_8000);       // half rounds up
    add_item(OP_MUL, -32'sd1, 32'sh0000_8000);      // negative half, asymmetric
    add_item(OP_MUL, -32'sd3, 32'sh0000_8000);
    add_item(OP_MUL, SatMax, SatMax);               // saturates high
    add_item(OP_MUL, SatMin, SatMax);               // saturates low
    add_item(OP_MUL, SatMin, SatMin);
    add_item(OP_DIV, 32'sh0001_0000, 32'sd0);       // zero divisor
    add_item(OP_DIV, -32'sh0001_0000, 32'sd0);      // zero divisor, negative
    add_item(OP_DIV, SatMax, 32'sd1);               // quotient overflow
    add_item(OP_DIV, SatMin, 32'sd1);               // overflow, clamps to -max
    add_item(OP_DIV, SatMin, -32'sd1);
    add_item(OP_DIV, 32'sh0003_0000, 32'sh0002_0000);
    add_item(OP_DIV, -32'sd7, SatMax);
    add_item(OP_DIV, SatMin, SatMin);
    add_item(OP_DIV, SatMax, SatMin);

    // random: phase one sender idles lightly, receiver heavily
    for (k = 0; k < 260; k++) add_item(op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait (pending_q.size() == 0);
    // long receiver hold-off while the sender keeps offering
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req     = 1'b1;
    for (k = 0; k < 120; k++) add_item(op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait (pending_q.size() == 0);
    send_gap_pct = 88;
    recv_gap_pct = 18;
    for (k = 0; k < 200; k++) add_item(op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait (pending_q.size() == 0);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (k = 0; k < 220; k++) add_item(op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    all_queued = 1'b1;
  end

  // driver: offers the head of the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.opcode        <= OP_ADD;
      in_if.left_operand  <= '0;
      in_if.right_operand <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(alu_result(pending_q[0]));
        op_seen[pending_q[0].op]++;
        n_sent++;
        void'(pending_q.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        // offered item waits unchanged until it is taken
      end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_if.valid         <= 1'b1;
        in_if.opcode        <= pending_q[0].op;
        in_if.left_operand  <= pending_q[0].lhs;
        in_if.right_operand <= pending_q[0].rhs;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter, long enough to fill the pipe
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= HoldOff;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: takes results and checks them in order
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DataW-1:0] exp_val;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result_value: no item waiting, actual %h", out_if.result_value);
          n_errors++;
        end else begin
          exp_val = expected_q.pop_front();
          if (out_if.result_value !== exp_val) begin
            $error("result_value: expected %h actual %h", exp_val, out_if.result_value);
            n_errors++;
          end
          n_checked++;
        end
      end
      out_if.ready <= (hold_cnt == 0 && !hold_req) && ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= StallLimit) begin
        $display("watchdog expired, %0d results outstanding", expected_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    n_errors = 0;
    n_sent   = 0;
    n_checked = 0;
    idle_cnt = 0;
    wait (all_queued && pending_q.size() == 0 && !in_if.valid);
    wait (expected_q.size() == 0);
    repeat (2 * Latency) @(posedge clk_i);
    $display("covered %0d items (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
             n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], n_checked);
    $display("idling both ways, a long receiver hold-off and back-to-back traffic");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
